@@ rtl/blhm_pkg.sv @@
// Package for the battery level hysteresis monitor.
// Holds the level codes, fixed-point polynomial constants and the
// config, command and status types shared by all modules.
`timescale 1ns / 1ps

package blhm_pkg;

    localparam int MV_W    = 14;
    localparam int CAL_W   = 12;
    localparam int HYST_W  = 12;
    localparam int PCT_W   = 7;
    localparam int TABLE_W = 28;
    localparam int LEVEL_W = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_ADDR_W-1:0] REG_SRC_MV = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIDLO  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIDHI  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HYST   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TABLE  = 3'd6;

    localparam logic [LEVEL_W-1:0] LVL_EMPTY = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_LOW   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MID   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_HIGH  = 2'd3;

    localparam logic [MV_W-1:0] MV_MAX = 14'd16383;

    // Horner stage widths
    localparam int ACC1_W  = 32;
    localparam int ACC2_W  = 48;
    localparam int ACC3_W  = 64;
    localparam int SPLIT_W = 24;
    localparam int FRAC_W  = 40;
    localparam int CMP_W   = 17;

    // Q40 millivolt coefficients
    localparam logic signed [ACC1_W-1:0] K3 = -32'sd52614;
    localparam logic signed [ACC1_W-1:0] K2 = 32'sd208348657;
    localparam logic signed [ACC2_W-1:0] K1 = 48'sd1639129944456;
    localparam logic signed [ACC3_W-1:0] K0 = 64'sd328204220891136;

    localparam logic [MV_W-1:0]    RST_LOW   = 14'd6600;
    localparam logic [MV_W-1:0]    RST_MIDLO = 14'd7000;
    localparam logic [MV_W-1:0]    RST_MIDHI = 14'd7600;
    localparam logic [HYST_W-1:0]  RST_HYST  = 12'd100;
    localparam logic [TABLE_W-1:0] RST_TABLE = 28'd210537600;

    typedef struct packed {
        logic                     src_mv;
        logic signed [CAL_W-1:0]  cal;
        logic [MV_W-1:0]          low;
        logic [MV_W-1:0]          midlo;
        logic [MV_W-1:0]          midhi;
        logic [HYST_W-1:0]        hyst;
        logic [TABLE_W-1:0]       table_bits;
    } cfg_t;

    typedef struct packed {
        logic load_sample;
        logic poly1;
        logic poly2;
        logic poly3_lo;
        logic poly3_hi;
        logic convert;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic src_mv;
        logic out_free;
    } status_t;

endpackage

@@ rtl/battery_level_hysteresis_monitor_top.sv @@
// Battery level monitor: turns one sample per transaction into a filtered
// millivolt value, a four-step level with hysteresis and a percentage. An ADC
// code passes through acceptance, four Horner steps, one offset add with
// saturation and one filter and classify step before the next input is
// taken; a millivolt sample goes from acceptance to the filter and classify
// step. The result sits in an output register, so a new sample is
// taken while the previous result waits; the commit step waits only while
// that register is still full. Configuration writes go straight to the
// register bank and must be made while no sample is in flight.
`timescale 1ns / 1ps

module battery_level_hysteresis_monitor_top
    import blhm_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MV_W-1:0]       s_sample_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MV_W-1:0]       m_filtered_mv,
    output logic [LEVEL_W-1:0]    m_level,
    output logic [PCT_W-1:0]      m_percent,
    output logic                  m_entered_empty
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_mv     <= 1'b0;
            cfg_reg.cal        <= '0;
            cfg_reg.low        <= RST_LOW;
            cfg_reg.midlo      <= RST_MIDLO;
            cfg_reg.midhi      <= RST_MIDHI;
            cfg_reg.hyst       <= RST_HYST;
            cfg_reg.table_bits <= RST_TABLE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SRC_MV: cfg_reg.src_mv     <= cfg_wdata[0];
                REG_CAL:    cfg_reg.cal        <= $signed(cfg_wdata[CAL_W-1:0]);
                REG_LOW:    cfg_reg.low        <= cfg_wdata[MV_W-1:0];
                REG_MIDLO:  cfg_reg.midlo      <= cfg_wdata[MV_W-1:0];
                REG_MIDHI:  cfg_reg.midhi      <= cfg_wdata[MV_W-1:0];
                REG_HYST:   cfg_reg.hyst       <= cfg_wdata[HYST_W-1:0];
                REG_TABLE:  cfg_reg.table_bits <= cfg_wdata[TABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    blhm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    blhm_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered_mv   (m_filtered_mv),
        .m_level         (m_level),
        .m_percent       (m_percent),
        .m_entered_empty (m_entered_empty)
    );

endmodule

@@ rtl/blhm_ctrl.sv @@
// Sequencer for the battery level monitor.
// Steps the datapath through polynomial conversion and commit; uses blhm_pkg.
`timescale 1ns / 1ps

module blhm_ctrl
    import blhm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_POLY1   = 3'd1;
    localparam logic [2:0] ST_POLY2   = 3'd2;
    localparam logic [2:0] ST_POLY3LO = 3'd3;
    localparam logic [2:0] ST_POLY3HI = 3'd4;
    localparam logic [2:0] ST_CONVERT = 3'd5;
    localparam logic [2:0] ST_COMMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next = status.src_mv ? ST_COMMIT : ST_POLY1;
                end
            end
            ST_POLY1: begin
                cmd.poly1  = 1'b1;
                state_next = ST_POLY2;
            end
            ST_POLY2: begin
                cmd.poly2  = 1'b1;
                state_next = ST_POLY3LO;
            end
            ST_POLY3LO: begin
                cmd.poly3_lo = 1'b1;
                state_next   = ST_POLY3HI;
            end
            ST_POLY3HI: begin
                cmd.poly3_hi = 1'b1;
                state_next   = ST_CONVERT;
            end
            ST_CONVERT: begin
                cmd.convert = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/blhm_datapath.sv @@
// Datapath for the battery level monitor: Horner evaluation, saturation,
// filter, level classifier and output register. Uses blhm_pkg.
`timescale 1ns / 1ps

module blhm_datapath
    import blhm_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [MV_W-1:0]    s_sample_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [MV_W-1:0]    m_filtered_mv,
    output logic [LEVEL_W-1:0] m_level,
    output logic [PCT_W-1:0]   m_percent,
    output logic               m_entered_empty
);

    localparam int XS_W  = ADC_BITS + 1;
    localparam int P2_W  = ACC1_W + XS_W;
    localparam int PLO_W = SPLIT_W + 1 + XS_W;
    localparam int PHI_W = (ACC2_W - SPLIT_W) + XS_W;

    logic [ADC_BITS-1:0]        sample_reg;
    logic [MV_W-1:0]            mv_reg;
    logic signed [ACC1_W-1:0]   acc1_reg;
    logic signed [ACC2_W-1:0]   acc2_reg;
    logic signed [PLO_W-1:0]    plo_reg;
    logic signed [ACC3_W-1:0]   acc3_reg;
    logic [MV_W-1:0]            filter_reg;
    logic [LEVEL_W-1:0]         level_reg;
    logic                       primed_reg;
    logic                       out_valid_reg;
    logic [MV_W-1:0]            out_mv_reg;
    logic [LEVEL_W-1:0]         out_level_reg;
    logic [PCT_W-1:0]           out_pct_reg;
    logic                       out_empty_reg;

    logic signed [XS_W-1:0]     xs;
    logic signed [ACC1_W-1:0]   prod1;
    logic signed [P2_W-1:0]     prod2;
    logic signed [PLO_W-1:0]    plo;
    logic signed [PHI_W-1:0]    phi;
    logic signed [ACC3_W-1:0]   acc3_next;
    logic signed [ACC3_W-1:0]   total;
    logic [MV_W-1:0]            sat_mv;

    logic [MV_W:0]              filt_sum;
    logic [MV_W-1:0]            filter_next;
    logic signed [CMP_W-1:0]    v;
    logic signed [CMP_W-1:0]    midlo_s;
    logic signed [CMP_W-1:0]    midhi_s;
    logic signed [CMP_W-1:0]    low_s;
    logic signed [CMP_W-1:0]    hyst_s;
    logic signed [CMP_W-1:0]    half_hyst_s;
    logic [LEVEL_W-1:0]         level_next;
    logic [PCT_W-1:0]           pct_next;

    assign xs    = $signed({1'b0, sample_reg});
    assign prod1 = K3 * ACC1_W'(xs);
    assign prod2 = P2_W'(acc1_reg) * P2_W'(xs);
    assign plo   = PLO_W'($signed({1'b0, acc2_reg[SPLIT_W-1:0]})) * PLO_W'(xs);
    assign phi   = PHI_W'($signed(acc2_reg[ACC2_W-1:SPLIT_W])) * PHI_W'(xs);

    assign acc3_next = (ACC3_W'(phi) <<< SPLIT_W) + ACC3_W'(plo_reg) + K0;
    assign total     = acc3_reg + (ACC3_W'(cfg.cal) <<< FRAC_W);

    always_comb begin
        if (total[ACC3_W-1]) begin
            sat_mv = '0;
        end else if (|total[ACC3_W-2:FRAC_W+MV_W]) begin
            sat_mv = MV_MAX;
        end else begin
            sat_mv = total[FRAC_W+MV_W-1:FRAC_W];
        end
    end

    assign filt_sum    = {1'b0, filter_reg} + {1'b0, mv_reg};
    assign filter_next = primed_reg ? filt_sum[MV_W:1] : mv_reg;

    assign v           = $signed(CMP_W'(filter_next));
    assign midlo_s     = $signed(CMP_W'(cfg.midlo));
    assign midhi_s     = $signed(CMP_W'(cfg.midhi));
    assign low_s       = $signed(CMP_W'(cfg.low));
    assign hyst_s      = $signed(CMP_W'(cfg.hyst));
    assign half_hyst_s = $signed(CMP_W'(cfg.hyst[HYST_W-1:1]));

    always_comb begin
        level_next = level_reg;
        case (level_reg)
            LVL_LOW: begin
                if (v > midlo_s + hyst_s) begin
                    level_next = LVL_MID;
                end
                if (v < low_s - half_hyst_s) begin
                    level_next = LVL_EMPTY;
                end
            end
            LVL_MID: begin
                if (v > midhi_s + hyst_s) begin
                    level_next = LVL_HIGH;
                end
                if (v < midlo_s - hyst_s) begin
                    level_next = LVL_LOW;
                end
            end
            LVL_HIGH: begin
                if (v < midhi_s - hyst_s) begin
                    level_next = LVL_MID;
                end
            end
            default: begin
                level_next = level_reg;
            end
        endcase
    end

    always_comb begin
        case (level_next)
            LVL_EMPTY: pct_next = cfg.table_bits[PCT_W-1:0];
            LVL_LOW:   pct_next = cfg.table_bits[2*PCT_W-1:PCT_W];
            LVL_MID:   pct_next = cfg.table_bits[3*PCT_W-1:2*PCT_W];
            default:   pct_next = cfg.table_bits[4*PCT_W-1:3*PCT_W];
        endcase
    end

    // Horner pipeline and converted sample
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_sample_value[ADC_BITS-1:0];
            mv_reg     <= s_sample_value;
        end
        if (cmd.poly1) begin
            acc1_reg <= prod1 + K2;
        end
        if (cmd.poly2) begin
            acc2_reg <= ACC2_W'(prod2) + K1;
        end
        if (cmd.poly3_lo) begin
            plo_reg <= plo;
        end
        if (cmd.poly3_hi) begin
            acc3_reg <= acc3_next;
        end
        if (cmd.convert) begin
            mv_reg <= sat_mv;
        end
    end

    // Filter and level state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
            level_reg  <= LVL_LOW;
            primed_reg <= 1'b0;
        end else if (cmd.commit) begin
            filter_reg <= filter_next;
            level_reg  <= level_next;
            primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_mv_reg    <= filter_next;
            out_level_reg <= level_next;
            out_pct_reg   <= pct_next;
            out_empty_reg <= (level_next == LVL_EMPTY) && (level_reg != LVL_EMPTY);
        end
    end

    assign status.src_mv   = cfg.src_mv;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_filtered_mv   = out_mv_reg;
    assign m_level         = out_level_reg;
    assign m_percent       = out_pct_reg;
    assign m_entered_empty = out_empty_reg;

endmodule
